>>> rtl/edf_pkg.sv
// Shared types, constants and codes for the preemptive EDF scheduler.
package edf_pkg;

    // Slot table
    localparam int TABLE_DEPTH = 16;
    localparam int SLOT_W      = $clog2(TABLE_DEPTH);

    // Field widths
    localparam int CLASS_COUNT = 3;
    localparam int CLASS_W     = 2;
    localparam int KIND_W      = 2;
    localparam int CFG_W       = 16;
    localparam int CFG_INDEX_W = 3;
    localparam int SERIAL_W    = 16;
    localparam int TIME_W      = 32;

    // Input operations
    localparam logic OP_ARRIVAL = 1'b0;
    localparam logic OP_TICK    = 1'b1;

    // Result kinds
    localparam logic [KIND_W-1:0] EV_RECEIVE = 2'd0;
    localparam logic [KIND_W-1:0] EV_FINISH  = 2'd1;
    localparam logic [KIND_W-1:0] EV_DROP    = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_C0_SERVICE  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_C0_DEADLINE = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_C1_SERVICE  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_C1_DEADLINE = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_C2_SERVICE  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_C2_DEADLINE = 3'd5;

    // Configuration reset values
    localparam logic [CFG_W-1:0] C0_SERVICE_RST  = 16'd500;
    localparam logic [CFG_W-1:0] C0_DEADLINE_RST = 16'd2000;
    localparam logic [CFG_W-1:0] C1_SERVICE_RST  = 16'd1000;
    localparam logic [CFG_W-1:0] C1_DEADLINE_RST = 16'd3000;
    localparam logic [CFG_W-1:0] C2_SERVICE_RST  = 16'd200;
    localparam logic [CFG_W-1:0] C2_DEADLINE_RST = 16'd300;

    typedef struct packed {
        logic               operation;
        logic [CLASS_W-1:0] job_class;
    } in_item_t;

    typedef struct packed {
        logic [KIND_W-1:0]   event_kind;
        logic [CLASS_W-1:0]  event_class;
        logic [SERIAL_W-1:0] event_serial;
        logic                last_event;
    } out_item_t;

endpackage

>>> rtl/preemptive_edf_scheduler_core.sv
// Top level of the preemptive earliest-deadline-first scheduler core.
//
// Usage:
//   in channel  (in_valid/in_ready/in_data): one beat is an arrival of a job
//     class or one time tick. in_ready is high only while the sequencer idles.
//   out channel (out_valid/out_ready/out_data): receive, finish and drop
//     events; last_event marks the final beat caused by one input beat.
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): always ready; writes
//     the six per-class service and deadline registers, other indexes ignored.
// Occupancy (accept to next possible accept):
//   arrival: the arrive state, plus the emit state when a drop is reported.
//   tick: the scan of the slot table, one slot per cycle through a single
//     deadline/age compare unit, then the update state and the emit state,
//     which queues each event in turn. An empty table skips the update state.
// Results go into a two-beat output queue, so a stalled receiver holds back the
// sequencer only when the queue is full; queued beats stay stable until taken.
// Reset clears the slot valid bits, counters, time, queue and configuration
// (to its default values); slot contents are not cleared and no pass is needed.
module preemptive_edf_scheduler_core
    import edf_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  in_item_t               in_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output out_item_t              out_data,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]       cfg_data
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_ARRIVE = 3'd1;
    localparam logic [2:0] ST_SCAN   = 3'd2;
    localparam logic [2:0] ST_UPDATE = 3'd3;
    localparam logic [2:0] ST_EMIT   = 3'd4;

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_DEPTH - 1);

    logic [2:0] state_reg, state_next;

    // Captured input beat
    logic               op_reg;
    logic [CLASS_W-1:0] cls_reg;

    // Configuration and global state
    logic [CFG_W-1:0]    svc_reg [CLASS_COUNT];
    logic [CFG_W-1:0]    ddl_reg [CLASS_COUNT];
    logic [SERIAL_W-1:0] cnt_reg [CLASS_COUNT];
    logic [TIME_W-1:0]   time_reg;
    logic [TIME_W-1:0]   age_cnt_reg;

    // Slot table
    logic [TABLE_DEPTH-1:0] valid_reg;
    logic [TIME_W-1:0]      dl_arr   [TABLE_DEPTH];
    logic [CFG_W-1:0]       rem_arr  [TABLE_DEPTH];
    logic [CLASS_W-1:0]     kind_arr [TABLE_DEPTH];
    logic [SERIAL_W-1:0]    num_arr  [TABLE_DEPTH];
    logic                   st_arr   [TABLE_DEPTH];
    logic [TIME_W-1:0]      age_arr  [TABLE_DEPTH];

    // Scan state
    logic [SLOT_W-1:0] scan_reg;
    logic              best_found_reg;
    logic [SLOT_W-1:0] best_idx_reg;
    logic [TIME_W-1:0] best_dl_reg;
    logic [TIME_W-1:0] best_age_reg;

    // Pending events of the current item
    out_item_t pend_reg [2];
    logic [1:0] pend_num_reg;
    logic       pend_pos_reg;

    // Output queue
    out_item_t q_reg [2];
    logic       q_head_reg;
    logic [1:0] q_cnt_reg;

    // Slot read port: scan pointer while scanning, chosen slot while updating
    logic [SLOT_W-1:0]   rd_idx;
    logic [TIME_W-1:0]   rd_dl;
    logic [TIME_W-1:0]   rd_age;
    logic [CFG_W-1:0]    rd_rem;
    logic [CLASS_W-1:0]  rd_kind;
    logic [SERIAL_W-1:0] rd_num;
    logic                rd_started;
    logic                cand_take;
    logic                found_next;

    // Arrival path
    logic                cls_ok;
    logic [1:0]          cls_idx;
    logic [SERIAL_W-1:0] serial_inc;
    logic [TIME_W-1:0]   new_dl;
    logic                free_any;
    logic [SLOT_W-1:0]   free_idx;

    // Update path
    logic      upd_recv;
    logic      upd_fin;
    out_item_t recv_item;
    out_item_t fin_item;
    out_item_t drop_item;

    // Emit / queue
    logic      in_fire;
    logic      q_push;
    logic      q_pop;
    logic      emit_last;
    out_item_t emit_item;

    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign in_fire   = in_valid && in_ready;

    assign rd_idx     = (state_reg == ST_UPDATE) ? best_idx_reg : scan_reg;
    assign rd_dl      = dl_arr[rd_idx];
    assign rd_age     = age_arr[rd_idx];
    assign rd_rem     = rem_arr[rd_idx];
    assign rd_kind    = kind_arr[rd_idx];
    assign rd_num     = num_arr[rd_idx];
    assign rd_started = st_arr[rd_idx];

    // The shared compare unit: earlier deadline wins, ties to the older arrival
    assign cand_take = valid_reg[rd_idx] &&
                       (!best_found_reg || (rd_dl < best_dl_reg) ||
                        ((rd_dl == best_dl_reg) && (rd_age < best_age_reg)));
    assign found_next = best_found_reg || cand_take;

    assign cls_ok     = (cls_reg < CLASS_W'(CLASS_COUNT));
    assign cls_idx    = cls_ok ? cls_reg : 2'd0;
    assign serial_inc = cnt_reg[cls_idx] + SERIAL_W'(1);
    assign new_dl     = time_reg + TIME_W'(ddl_reg[cls_idx]);

    // Lowest free slot
    always_comb
    begin
        free_any = 1'b0;
        free_idx = '0;
        for (int i = TABLE_DEPTH - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_any = 1'b1;
                free_idx = SLOT_W'(i);
            end
        end
    end

    assign upd_recv = !rd_started;
    assign upd_fin  = (rd_rem <= CFG_W'(1));

    always_comb
    begin
        recv_item.event_kind   = EV_RECEIVE;
        recv_item.event_class  = rd_kind;
        recv_item.event_serial = rd_num;
        recv_item.last_event   = !upd_fin;
        fin_item.event_kind    = EV_FINISH;
        fin_item.event_class   = rd_kind;
        fin_item.event_serial  = rd_num;
        fin_item.last_event    = 1'b1;
        drop_item.event_kind   = EV_DROP;
        drop_item.event_class  = cls_reg;
        drop_item.event_serial = serial_inc;
        drop_item.last_event   = 1'b1;
    end

    assign emit_item = pend_reg[pend_pos_reg];
    assign emit_last = pend_pos_reg || (pend_num_reg == 2'd1);
    assign q_push    = (state_reg == ST_EMIT) && (q_cnt_reg != 2'd2);
    assign q_pop     = out_valid && out_ready;
    assign out_valid = (q_cnt_reg != 2'd0);
    assign out_data  = q_reg[q_head_reg];

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                    state_next = (in_data.operation == OP_TICK) ? ST_SCAN : ST_ARRIVE;
            end
            ST_ARRIVE:
            begin
                state_next = (cls_ok && !free_any) ? ST_EMIT : ST_IDLE;
            end
            ST_SCAN:
            begin
                if (scan_reg == LAST_SLOT)
                    state_next = found_next ? ST_UPDATE : ST_IDLE;
            end
            ST_UPDATE:
            begin
                state_next = (upd_recv || upd_fin) ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT:
            begin
                if (q_push && emit_last)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            svc_reg[0]     <= C0_SERVICE_RST;
            ddl_reg[0]     <= C0_DEADLINE_RST;
            svc_reg[1]     <= C1_SERVICE_RST;
            ddl_reg[1]     <= C1_DEADLINE_RST;
            svc_reg[2]     <= C2_SERVICE_RST;
            ddl_reg[2]     <= C2_DEADLINE_RST;
            for (int c = 0; c < CLASS_COUNT; c++)
            begin
                cnt_reg[c] <= '0;
            end
            time_reg       <= '0;
            age_cnt_reg    <= '0;
            valid_reg      <= '0;
            scan_reg       <= '0;
            best_found_reg <= 1'b0;
            pend_num_reg   <= 2'd0;
            pend_pos_reg   <= 1'b0;
            q_head_reg     <= 1'b0;
            q_cnt_reg      <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_C0_SERVICE:  svc_reg[0] <= cfg_data;
                    REG_C0_DEADLINE: ddl_reg[0] <= cfg_data;
                    REG_C1_SERVICE:  svc_reg[1] <= cfg_data;
                    REG_C1_DEADLINE: ddl_reg[1] <= cfg_data;
                    REG_C2_SERVICE:  svc_reg[2] <= cfg_data;
                    REG_C2_DEADLINE: ddl_reg[2] <= cfg_data;
                    default: ;
                endcase
            end

            case (state_reg)
                ST_IDLE:
                begin
                    scan_reg       <= '0;
                    best_found_reg <= 1'b0;
                    pend_pos_reg   <= 1'b0;
                end
                ST_ARRIVE:
                begin
                    if (cls_ok)
                    begin
                        if (free_any)
                        begin
                            cnt_reg[cls_idx]    <= serial_inc;
                            valid_reg[free_idx] <= 1'b1;
                            age_cnt_reg         <= age_cnt_reg + TIME_W'(1);
                        end
                        else
                        begin
                            pend_num_reg <= 2'd1;
                        end
                    end
                end
                ST_SCAN:
                begin
                    scan_reg       <= scan_reg + SLOT_W'(1);
                    best_found_reg <= found_next;
                    if ((scan_reg == LAST_SLOT) && !found_next)
                        time_reg <= time_reg + TIME_W'(1);
                end
                ST_UPDATE:
                begin
                    time_reg     <= time_reg + TIME_W'(1);
                    pend_num_reg <= {1'b0, upd_recv} + {1'b0, upd_fin};
                    if (upd_fin)
                        valid_reg[best_idx_reg] <= 1'b0;
                end
                ST_EMIT:
                begin
                    if (q_push)
                        pend_pos_reg <= 1'b1;
                end
                default: ;
            endcase

            if (q_pop)
                q_head_reg <= !q_head_reg;
            q_cnt_reg <= q_cnt_reg + {1'b0, q_push} - {1'b0, q_pop};
        end
    end

    // Payload: captured beat, slot contents, scan best, pending and queued events
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            op_reg  <= in_data.operation;
            cls_reg <= in_data.job_class;
        end

        if ((state_reg == ST_ARRIVE) && cls_ok && free_any)
        begin
            dl_arr[free_idx]   <= new_dl;
            rem_arr[free_idx]  <= svc_reg[cls_idx];
            kind_arr[free_idx] <= cls_reg;
            num_arr[free_idx]  <= serial_inc;
            st_arr[free_idx]   <= 1'b0;
            age_arr[free_idx]  <= age_cnt_reg;
        end

        if ((state_reg == ST_ARRIVE) && (op_reg == OP_ARRIVAL))
            pend_reg[0] <= drop_item;

        if ((state_reg == ST_SCAN) && cand_take)
        begin
            best_idx_reg <= scan_reg;
            best_dl_reg  <= rd_dl;
            best_age_reg <= rd_age;
        end

        if (state_reg == ST_UPDATE)
        begin
            rem_arr[best_idx_reg] <= upd_fin ? '0 : (rd_rem - CFG_W'(1));
            st_arr[best_idx_reg]  <= 1'b1;
            pend_reg[0]           <= upd_recv ? recv_item : fin_item;
            pend_reg[1]           <= fin_item;
        end

        if (q_push)
            q_reg[q_head_reg ^ q_cnt_reg[0]] <= emit_item;
    end

endmodule

>>> rtl/edf_checker.sv
// Port-level assertions for the preemptive EDF scheduler core, bound to the top level.
module edf_checker
    import edf_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_valid,
    input logic                   in_ready,
    input in_item_t               in_data,
    input logic                   out_valid,
    input logic                   out_ready,
    input out_item_t              out_data
);

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output beat changed while stalled");

    // A tick occupies the sequencer for the whole table scan
    a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_data.operation == OP_TICK)
        |-> ##(TABLE_DEPTH) !in_ready)
        else $error("input accepted during table scan");

    // Any accepted beat makes the block busy in the next cycle
    a_busy_after: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("back-to-back input accept");

    // Drops are single-beat results and no undefined kind appears
    a_drop_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.event_kind != 2'd3) &&
                      ((out_data.event_kind != EV_DROP) || out_data.last_event))
        else $error("bad result kind or drop not marked last");

endmodule

bind preemptive_edf_scheduler_core edf_checker u_edf_checker (.*);

>>> bench/preemptive_edf_scheduler_core_tb.sv
// Self-checking bench for the preemptive EDF scheduler core: predicted events vs. DUT output.
module preemptive_edf_scheduler_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import edf_pkg::*;

    // Job classes as they appear in the job_class field; the fourth code means nothing.
    localparam logic [CLASS_W-1:0] CLASS_ORDINARY  = 2'd0;
    localparam logic [CLASS_W-1:0] CLASS_PATIENT   = 2'd1;
    localparam logic [CLASS_W-1:0] CLASS_IMPATIENT = 2'd2;
    localparam logic [CLASS_W-1:0] CLASS_NONE      = 2'd3;

    // Register indexes past the six class registers; writes there must be ignored.
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 3'd7;

    // Long enough for a full tick or arrival to finish, with margin.
    localparam int SETTLE_CYCLES  = 30;
    // Cycles without any handshake before the run is declared hung. Worst legal
    // case: the longest send gap, a full tick and two of the longest output stalls.
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic [CFG_INDEX_W-1:0] index;
        logic [CFG_W-1:0]       value;
    } reg_write_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    in_item_t               in_data;
    logic                   out_valid;
    logic                   out_ready;
    out_item_t              out_data;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_W-1:0]       cfg_data;

    preemptive_edf_scheduler_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Scheduler shadow: job table, counters and class settings.
    // Slot contents are only read while the slot is busy, so they need no reset.
    // ------------------------------------------------------------------
    logic                slot_busy     [TABLE_DEPTH];
    logic [TIME_W-1:0]   slot_deadline [TABLE_DEPTH];
    logic [CFG_W-1:0]    slot_work     [TABLE_DEPTH];
    logic [CLASS_W-1:0]  slot_class    [TABLE_DEPTH];
    logic [SERIAL_W-1:0] slot_serial   [TABLE_DEPTH];
    logic                slot_started  [TABLE_DEPTH];
    logic [TIME_W-1:0]   slot_order    [TABLE_DEPTH];
    logic [TIME_W-1:0]   arrivals_so_far;
    logic [SERIAL_W-1:0] class_serial  [CLASS_COUNT];
    logic [TIME_W-1:0]   now_ticks;
    logic [CFG_W-1:0]    service_cfg   [CLASS_COUNT];
    logic [CFG_W-1:0]    deadline_cfg  [CLASS_COUNT];

    in_item_t  request_queue[$];   // beats waiting for the driver
    out_item_t pending_events[$];  // events predicted but not yet seen

    logic in_taken;
    logic cfg_taken;
    int   send_gap;
    int   stall_left;
    int   idle_cycles;
    bit   steady;                  // phase runs with no idling on either side

    int fail_count;
    int items_taken;
    int writes_done;
    int receives_seen;
    int finishes_seen;
    int drops_seen;

    // Mostly back to back, some short gaps, a few long ones; none while steady.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void store_register(input logic [CFG_INDEX_W-1:0] idx,
                                           input logic [CFG_W-1:0]       val);
        case (idx)
            REG_C0_SERVICE:  service_cfg[CLASS_ORDINARY]   = val;
            REG_C0_DEADLINE: deadline_cfg[CLASS_ORDINARY]  = val;
            REG_C1_SERVICE:  service_cfg[CLASS_PATIENT]    = val;
            REG_C1_DEADLINE: deadline_cfg[CLASS_PATIENT]   = val;
            REG_C2_SERVICE:  service_cfg[CLASS_IMPATIENT]  = val;
            REG_C2_DEADLINE: deadline_cfg[CLASS_IMPATIENT] = val;
            default: ;
        endcase
    endfunction

    // Advance the shadow by one accepted beat and queue the events it causes.
    function automatic void forecast_events(input in_item_t req);
        int        i;
        int        free_slot;
        int        best;
        out_item_t ev;
        out_item_t evs[$];
        free_slot = -1;
        best      = -1;
        ev        = '0;
        if (req.operation == OP_ARRIVAL) begin
            // Unused class code: dropped silently, nothing stored.
            if (req.job_class >= CLASS_COUNT)
                return;
            for (i = 0; i < TABLE_DEPTH; i++)
                if (!slot_busy[i] && free_slot < 0)
                    free_slot = i;
            if (free_slot < 0) begin
                // Full table: report the serial the job would have had, no advance.
                ev.event_kind   = EV_DROP;
                ev.event_class  = req.job_class;
                ev.event_serial = class_serial[req.job_class] + 1'b1;
                ev.last_event   = 1'b1;
                pending_events.push_back(ev);
                return;
            end
            class_serial[req.job_class] = class_serial[req.job_class] + 1'b1;
            slot_busy[free_slot]     = 1'b1;
            slot_deadline[free_slot] = now_ticks + TIME_W'(deadline_cfg[req.job_class]);
            slot_work[free_slot]     = service_cfg[req.job_class];
            slot_class[free_slot]    = req.job_class;
            slot_serial[free_slot]   = class_serial[req.job_class];
            slot_started[free_slot]  = 1'b0;
            slot_order[free_slot]    = arrivals_so_far;
            arrivals_so_far          = arrivals_so_far + 1'b1;
            return;
        end
        // Tick: earliest deadline wins, equal deadlines go to the older arrival.
        for (i = 0; i < TABLE_DEPTH; i++) begin
            if (slot_busy[i] &&
                (best < 0 ||
                 slot_deadline[i] < slot_deadline[best] ||
                 (slot_deadline[i] == slot_deadline[best] &&
                  slot_order[i] < slot_order[best])))
                best = i;
        end
        if (best >= 0) begin
            ev.event_class  = slot_class[best];
            ev.event_serial = slot_serial[best];
            if (!slot_started[best]) begin
                slot_started[best] = 1'b1;
                ev.event_kind      = EV_RECEIVE;
                evs.push_back(ev);
            end
            // A zero service count also finishes on its first tick.
            if (slot_work[best] <= 1) begin
                slot_work[best] = '0;
                slot_busy[best] = 1'b0;
                ev.event_kind   = EV_FINISH;
                evs.push_back(ev);
            end
            else begin
                slot_work[best] = slot_work[best] - 1'b1;
            end
        end
        now_ticks = now_ticks + 1'b1;
        if (evs.size() > 0)
            evs[evs.size() - 1].last_event = 1'b1;
        foreach (evs[k])
            pending_events.push_back(evs[k]);
    endfunction

    function automatic void check_event(input out_item_t got);
        out_item_t want;
        case (got.event_kind)
            EV_RECEIVE: receives_seen++;
            EV_FINISH:  finishes_seen++;
            EV_DROP:    drops_seen++;
            default: ;
        endcase
        if (pending_events.size() == 0) begin
            $display("%0t: unexpected event: kind %0d class %0d serial %0d last %0b",
                     $time, got.event_kind, got.event_class, got.event_serial,
                     got.last_event);
            fail_count++;
            return;
        end
        want = pending_events.pop_front();
        if (got.event_kind !== want.event_kind || got.event_class !== want.event_class ||
            got.event_serial !== want.event_serial || got.last_event !== want.last_event)
        begin
            $display("%0t: event mismatch: expected kind %0d class %0d serial %0d last %0b",
                     $time, want.event_kind, want.event_class, want.event_serial,
                     want.last_event);
            $display("%0t:                 actual   kind %0d class %0d serial %0d last %0b",
                     $time, got.event_kind, got.event_class, got.event_serial,
                     got.last_event);
            fail_count++;
        end
    endfunction

    // ------------------------------------------------------------------
    // Driver: one beat per handshake, random gaps between beats.
    // Inputs move on the falling edge only.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || in_taken) begin
            if (send_gap > 0) begin
                in_valid <= 1'b0;
                send_gap <= send_gap - 1;
            end
            else if (request_queue.size() > 0) begin
                in_valid <= 1'b1;
                in_data  <= request_queue.pop_front();
                send_gap <= pick_gap();
            end
            else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver backpressure: stalls start at random points, so they land on
    // every stage of a tick and between the two beats of one.
    always @(negedge clk)
    begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end
        else if (stall_left > 0) begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else begin
            out_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0)
                stall_left <= pick_gap();
        end
    end

    // ------------------------------------------------------------------
    // Monitor: everything is sampled at the rising edge. Accepted input beats
    // feed the shadow, register writes update its settings, output beats are
    // checked against the oldest prediction. The watchdog lives here too.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        in_taken  <= in_valid && in_ready;
        cfg_taken <= cfg_valid && cfg_ready;
        if (rst_n) begin
            if (in_valid && in_ready) begin
                forecast_events(in_data);
                items_taken++;
            end
            if (cfg_valid && cfg_ready) begin
                store_register(cfg_index, cfg_data);
                writes_done++;
            end
            if (out_valid && out_ready)
                check_event(out_data);
            if ((in_valid && in_ready) || (out_valid && out_ready) ||
                (cfg_valid && cfg_ready)) begin
                idle_cycles <= 0;
            end
            else if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no handshake for %0d cycles, %0d events outstanding",
                         $time, idle_cycles, pending_events.size());
                $display("preemptive_edf_scheduler_core_tb failed");
                $finish;
            end
            else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_request(input logic op, input logic [CLASS_W-1:0] cls);
        in_item_t req;
        req.operation = op;
        req.job_class = cls;
        request_queue.push_back(req);
    endtask

    // Random mix; unused-class arrivals ride along but are not counted.
    task automatic queue_random(input int count, input int arrival_pct);
        int taken;
        taken = 0;
        while (taken < count) begin
            if ($urandom_range(0, 99) < arrival_pct) begin
                if ($urandom_range(0, 19) == 0) begin
                    push_request(OP_ARRIVAL, CLASS_NONE);
                end
                else begin
                    push_request(OP_ARRIVAL, CLASS_W'($urandom_range(0, CLASS_COUNT - 1)));
                    taken++;
                end
            end
            else begin
                // Class bits are don't-care on a tick; toggle them anyway.
                push_request(OP_TICK, CLASS_W'($urandom_range(0, 3)));
                taken++;
            end
        end
    endtask

    // Sender holds off until the queue, the wire and the scoreboard are all
    // empty, then lets the core finish any arrival that produced no event.
    task automatic drain();
        do @(posedge clk);
        while (request_queue.size() != 0 || in_valid || pending_events.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Called on a falling edge with the core idle. Valid stays up across
    // back-to-back writes; a spare index gets junk that must change nothing.
    task automatic program_classes(input logic [CFG_W-1:0] s0, d0, s1, d1, s2, d2);
        reg_write_t writes[$];
        writes.push_back('{REG_C0_SERVICE,  s0});
        writes.push_back('{REG_C0_DEADLINE, d0});
        writes.push_back('{REG_C1_SERVICE,  s1});
        writes.push_back('{REG_C1_DEADLINE, d1});
        writes.push_back('{REG_C2_SERVICE,  s2});
        writes.push_back('{REG_C2_DEADLINE, d2});
        writes.push_back('{($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI),
                           CFG_W'($urandom)});
        foreach (writes[k]) begin
            cfg_valid <= 1'b1;
            cfg_index <= writes[k].index;
            cfg_data  <= writes[k].value;
            do @(negedge clk);
            while (!cfg_taken);
        end
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        int i;
        int phase;
        int arrival_mix [5];

        arrival_mix = '{35, 50, 65, 45, 55};

        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_data    = '0;
        out_ready  = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        in_taken   = 1'b0;
        cfg_taken  = 1'b0;
        send_gap   = 0;
        stall_left = 0;
        idle_cycles = 0;
        steady     = 1'b0;
        fail_count = 0;
        items_taken = 0;
        writes_done = 0;
        receives_seen = 0;
        finishes_seen = 0;
        drops_seen = 0;

        // Shadow mirrors the reset state of the core.
        for (i = 0; i < TABLE_DEPTH; i++)
            slot_busy[i] = 1'b0;
        for (i = 0; i < CLASS_COUNT; i++)
            class_serial[i] = '0;
        arrivals_so_far = '0;
        now_ticks       = '0;
        service_cfg[CLASS_ORDINARY]   = C0_SERVICE_RST;
        deadline_cfg[CLASS_ORDINARY]  = C0_DEADLINE_RST;
        service_cfg[CLASS_PATIENT]    = C1_SERVICE_RST;
        deadline_cfg[CLASS_PATIENT]   = C1_DEADLINE_RST;
        service_cfg[CLASS_IMPATIENT]  = C2_SERVICE_RST;
        deadline_cfg[CLASS_IMPATIENT] = C2_DEADLINE_RST;

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, reset settings: a tick on an empty table only moves time;
        // one job per class, then a tick that starts the impatient one. These
        // long jobs stay behind and compete with everything that follows.
        push_request(OP_TICK, CLASS_NONE);
        push_request(OP_ARRIVAL, CLASS_ORDINARY);
        push_request(OP_ARRIVAL, CLASS_PATIENT);
        push_request(OP_ARRIVAL, CLASS_IMPATIENT);
        push_request(OP_TICK, CLASS_PATIENT);
        drain();

        // Zero service and zero deadline on the patient class, the widest
        // deadline on the impatient one.
        program_classes(16'd1, 16'd5, 16'd0, 16'd0, 16'd2, 16'hFFFF);
        @(posedge clk);
        push_request(OP_ARRIVAL, CLASS_NONE);
        push_request(OP_ARRIVAL, CLASS_PATIENT);
        push_request(OP_ARRIVAL, CLASS_ORDINARY);
        push_request(OP_ARRIVAL, CLASS_IMPATIENT);
        push_request(OP_TICK, CLASS_ORDINARY);   // zero work: receive and finish
        push_request(OP_TICK, CLASS_IMPATIENT);  // one unit: receive and finish
        push_request(OP_TICK, CLASS_NONE);       // resumes a started job, silent
        // Fill the table; same-class jobs share a deadline so age breaks ties.
        for (i = 0; i < 12; i++)
            push_request(OP_ARRIVAL, CLASS_W'(i % CLASS_COUNT));
        push_request(OP_ARRIVAL, CLASS_PATIENT); // table full: drop
        drain();

        // Random phases: short jobs and tight deadlines so the table churns,
        // with load varied between light and overloaded. Phase 2 never idles.
        for (phase = 0; phase < 5; phase++) begin
            program_classes(CFG_W'($urandom_range(1, 10)), CFG_W'($urandom_range(1, 300)),
                            CFG_W'($urandom_range(1, 10)), CFG_W'($urandom_range(1, 300)),
                            CFG_W'($urandom_range(1, 10)), CFG_W'($urandom_range(1, 300)));
            steady = (phase == 2);
            @(posedge clk);
            queue_random(290, arrival_mix[phase]);
            drain();
        end
        steady = 1'b0;

        // Register extremes: deadline of one tick, endless patient jobs that
        // yield to every earlier deadline, impatient jobs with no work.
        program_classes(16'd1, 16'd1, 16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF);
        @(posedge clk);
        queue_random(60, 50);
        drain();

        $display("covered %0d input beats and %0d register writes over 7 settings",
                 items_taken, writes_done);
        $display("events checked: %0d receive, %0d finish, %0d drop; %0d mismatches",
                 receives_seen, finishes_seen, drops_seen, fail_count);
        if (fail_count == 0)
            $display("preemptive_edf_scheduler_core_tb passed");
        else
            $display("preemptive_edf_scheduler_core_tb failed");
        $finish;
    end

endmodule

>>> preemptive_edf_scheduler_core.f
rtl/edf_pkg.sv
rtl/preemptive_edf_scheduler_core.sv
rtl/edf_checker.sv
bench/preemptive_edf_scheduler_core_tb.sv
